[hw/rtl/sha1he_pkg.sv]
// ----------------------------------------------------------------------------
// sha1he_pkg
// Shared types, constants and helpers for the SHA-1 hash engine.
// ----------------------------------------------------------------------------
package sha1he_pkg;

    localparam int DIGEST_WORDS = 5;

    typedef logic [31:0] t_word;

    localparam t_word H_INIT [DIGEST_WORDS] = '{
        32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
    };

    localparam t_word K_CH  = 32'h5a827999;
    localparam t_word K_PA1 = 32'h6ed9eba1;
    localparam t_word K_MAJ = 32'h8f1bbcdc;
    localparam t_word K_PA2 = 32'hca62c1d6;

    localparam logic [6:0] ROUND_END_CH  = 7'd20;
    localparam logic [6:0] ROUND_END_PA1 = 7'd40;
    localparam logic [6:0] ROUND_END_MAJ = 7'd60;
    localparam logic [6:0] LAST_ROUND    = 7'd79;

    localparam logic [5:0] FILL_FULL = 6'd63;
    localparam logic [5:0] LEN_START = 6'd56;
    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam logic [2:0] LAST_OUT  = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_COMP,
        S_ADD,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        P_MARK,
        P_ZERO,
        P_LEN
    } t_pad;

    // Sequencer to datapath control
    typedef struct packed {
        logic       load;      // shift one byte into the block window
        logic [7:0] din;
        logic       start;     // load working vars from chaining words
        logic       round_en;  // run one round
        logic [6:0] round;
        logic       add;       // fold working vars into chaining words
        logic       clear;     // back to initial chaining value
        logic [2:0] out_idx;
    } t_ctl;

    function automatic t_word rotl1(t_word v);
        return {v[30:0], v[31]};
    endfunction

    function automatic t_word rotl5(t_word v);
        return {v[26:0], v[31:27]};
    endfunction

    function automatic t_word rotl30(t_word v);
        return {v[1:0], v[31:2]};
    endfunction

endpackage

[hw/rtl/sha1_hash_engine_unit.sv]
// ----------------------------------------------------------------------------
// sha1_hash_engine_unit
// SHA-1 engine fed one byte per transfer, emitting five 32-bit digest words.
// ----------------------------------------------------------------------------
// Input stream: tdata carries a message byte, tuser flags that the byte is
// part of the message, tlast ends the message (it may carry no byte, so an
// empty message works). Output stream: five transfers of one digest word
// each, H0 first; tlast marks the fifth.
// A byte that does not fill the 64-byte block just shifts into the window. A
// byte that fills it starts compression: the 80 rounds run on the single
// shared round unit, then the working variables are folded into the chaining
// words, and no new byte is taken until that is done.
// On tlast the sequencer shifts in 0x80, zero fill and the 64-bit length one
// byte per cycle (with one extra compression when the marker and length do
// not fit in the block), then compresses and presents the digest.
// s_axis_tready is low from a block-filling byte or a tlast transfer until the
// engine is idle again. Digest words are held while m_axis_tready is low;
// after the fifth transfer the engine returns to the initial chaining value.
// Reset is synchronous, active low, and leaves the engine idle and empty.
// ----------------------------------------------------------------------------
module sha1_hash_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] has_byte
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic        m_axis_tlast    // last_word
);
    import sha1he_pkg::*;

    t_state      r_state, n_state;
    t_pad        r_pad, n_pad;
    logic [5:0]  r_fill, n_fill;
    logic [60:0] r_total, n_total;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_oidx, n_oidx;
    logic        r_in_pad, n_in_pad;
    t_ctl        ctl;
    t_word       w;
    t_word       digest;
    logic [63:0] len_shift;

    // length byte for positions 56..63, most significant first
    assign len_shift = {r_total, 3'b000} >> {~r_fill[2:0], 3'b000};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pad    <= P_MARK;
            r_fill   <= '0;
            r_total  <= '0;
            r_round  <= '0;
            r_oidx   <= '0;
            r_in_pad <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pad    <= n_pad;
            r_fill   <= n_fill;
            r_total  <= n_total;
            r_round  <= n_round;
            r_oidx   <= n_oidx;
            r_in_pad <= n_in_pad;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_pad         = r_pad;
        n_fill        = r_fill;
        n_total       = r_total;
        n_round       = r_round;
        n_oidx        = r_oidx;
        n_in_pad      = r_in_pad;
        ctl           = '0;
        ctl.din       = s_axis_tdata;
        ctl.round     = r_round;
        ctl.out_idx   = r_oidx;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        m_axis_tlast  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser) begin
                        ctl.load = 1'b1;
                        n_fill   = r_fill + 6'd1;
                        n_total  = r_total + 61'd1;
                        if (r_fill == FILL_FULL) begin
                            ctl.start = 1'b1;
                            n_round   = '0;
                            n_in_pad  = s_axis_tlast;
                            n_state   = S_COMP;
                        end else if (s_axis_tlast) begin
                            n_in_pad = 1'b1;
                            n_state  = S_PAD;
                        end
                    end else if (s_axis_tlast) begin
                        n_in_pad = 1'b1;
                        n_state  = S_PAD;
                    end
                end
            end
            S_PAD: begin
                ctl.load = 1'b1;
                n_fill   = r_fill + 6'd1;
                if (r_pad == P_MARK) begin
                    ctl.din = PAD_MARK;
                    n_pad   = P_ZERO;
                end else if (r_pad == P_ZERO && r_fill != LEN_START) begin
                    ctl.din = 8'h00;
                end else begin
                    ctl.din = len_shift[7:0];
                    n_pad   = P_LEN;
                end
                if (r_fill == FILL_FULL) begin
                    ctl.start = 1'b1;
                    n_round   = '0;
                    n_state   = S_COMP;
                end
            end
            S_COMP: begin
                ctl.round_en = 1'b1;
                n_round      = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                ctl.add = 1'b1;
                n_round = '0;
                if (!r_in_pad) begin
                    n_state = S_IDLE;
                end else if (r_pad == P_LEN) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_PAD;
                end
            end
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                m_axis_tlast  = (r_oidx == LAST_OUT);
                if (m_axis_tready) begin
                    if (r_oidx == LAST_OUT) begin
                        ctl.clear = 1'b1;
                        n_oidx    = '0;
                        n_total   = '0;
                        n_fill    = '0;
                        n_in_pad  = 1'b0;
                        n_pad     = P_MARK;
                        n_state   = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + 3'd1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    sha1he_msg u_msg (
        .i_clk (i_clk),
        .i_ctl (ctl),
        .o_w   (w)
    );

    sha1he_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_w           (w),
        .o_digest_word (digest)
    );

    assign m_axis_tdata = digest;

endmodule

[hw/rtl/sha1he_msg.sv]
// ----------------------------------------------------------------------------
// sha1he_msg
// 512-bit block window: collects message bytes and, during compression,
// serves as the 16-word sliding message schedule.
// ----------------------------------------------------------------------------
module sha1he_msg (
    input  logic              i_clk,
    input  sha1he_pkg::t_ctl  i_ctl,
    output sha1he_pkg::t_word o_w
);
    import sha1he_pkg::*;

    logic [511:0] r_win;
    logic [511:0] n_win;
    t_word        w_new;

    // word j of the window sits at [511-32j -: 32]; w[t+16] from words 13, 8, 2, 0
    assign w_new = rotl1(r_win[95:64] ^ r_win[255:224] ^ r_win[447:416] ^ r_win[511:480]);
    assign o_w   = r_win[511:480];

    always_comb begin
        n_win = r_win;
        if (i_ctl.load) begin
            n_win = {r_win[503:0], i_ctl.din};
        end else if (i_ctl.round_en) begin
            n_win = {r_win[479:0], w_new};
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
    end

endmodule

[hw/rtl/sha1he_core.sv]
// ----------------------------------------------------------------------------
// sha1he_core
// Shared SHA-1 round unit with working variables and chaining words.
// ----------------------------------------------------------------------------
module sha1he_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sha1he_pkg::t_ctl  i_ctl,
    input  sha1he_pkg::t_word i_w,
    output sha1he_pkg::t_word o_digest_word
);
    import sha1he_pkg::*;

    t_word r_a, r_b, r_c, r_d, r_e;
    t_word r_h [DIGEST_WORDS];
    t_word f;
    t_word k;
    t_word t_sum;

    always_comb begin
        if (i_ctl.round < ROUND_END_CH) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K_CH;
        end else if (i_ctl.round < ROUND_END_PA1) begin
            f = r_b ^ r_c ^ r_d;
            k = K_PA1;
        end else if (i_ctl.round < ROUND_END_MAJ) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K_MAJ;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K_PA2;
        end
    end

    assign t_sum = rotl5(r_a) + f + r_e + k + i_w;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (i_ctl.round_en) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= rotl30(r_b);
            r_d <= r_c;
            r_e <= r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_h <= H_INIT;
        end else if (i_ctl.add) begin
            r_h[0] <= r_h[0] + r_a;
            r_h[1] <= r_h[1] + r_b;
            r_h[2] <= r_h[2] + r_c;
            r_h[3] <= r_h[3] + r_d;
            r_h[4] <= r_h[4] + r_e;
        end
    end

    assign o_digest_word = r_h[i_ctl.out_idx];

endmodule

[hw/rtl/sha1he_chk.sv]
// ----------------------------------------------------------------------------
// sha1he_chk
// Port-level checks for the SHA-1 hash engine, bound to the top level.
// ----------------------------------------------------------------------------
module sha1he_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tlast
);

    // input side and digest output are never open together
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while digest is presented");

    // message end always makes the engine busy (padding or compression)
    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("ready right after end of message");

    // after the final digest transfer the engine is idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready && !m_axis_tvalid)
        else $error("engine not idle after final digest word");

    // stalled digest word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("digest word changed under stall");

endmodule

bind sha1_hash_engine_unit sha1he_chk u_sha1he_chk (.*);
